/* design/scsirb_pkg.sv */
// Shared types, codes and helpers for the SCSI controller register block.
`timescale 1ns / 1ps
`default_nettype none

package scsirb_pkg;

    // Command FIFO geometry
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // Item kinds carried on tuser
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_DMA   = 2'd3;

    // Register map
    localparam logic [3:0] ADDR_CNT_LO  = 4'd0;
    localparam logic [3:0] ADDR_CNT_MID = 4'd1;
    localparam logic [3:0] ADDR_FIFO    = 4'd2;
    localparam logic [3:0] ADDR_CMD     = 4'd3;
    localparam logic [3:0] ADDR_STATUS  = 4'd4;
    localparam logic [3:0] ADDR_IRQ     = 4'd5;
    localparam logic [3:0] ADDR_ISTATE  = 4'd6;
    localparam logic [3:0] ADDR_FSTATE  = 4'd7;
    localparam logic [3:0] ADDR_CNT_HI  = 4'd14;

    // Commands (low seven bits, bit 7 is the DMA flag)
    localparam logic [6:0] CMD_NOP        = 7'h00;
    localparam logic [6:0] CMD_RESET_DEV  = 7'h03;
    localparam logic [6:0] CMD_SELECT_ATN = 7'h42;
    localparam logic [6:0] CMD_ENABLE_SEL = 7'h44;
    localparam logic [6:0] CMD_XFER_INFO  = 7'h10;
    localparam logic [6:0] CMD_INIT_CMPL  = 7'h11;
    localparam logic [6:0] CMD_MSG_ACCEPT = 7'h12;

    // Target opcodes that finish without a data phase
    localparam logic [7:0] OPC_TEST_UNIT    = 8'h00;
    localparam logic [7:0] OPC_PLAY_TRK_IDX = 8'h48;
    localparam logic [7:0] OPC_PAUSE_RESUME = 8'h4b;

    // Register values and bit positions
    localparam logic [7:0] ISTAT_DONE      = 8'h08;
    localparam logic [7:0] ISTATE_CMD_DONE = 8'h04;
    localparam logic [7:0] ISTATE_SEQ_DONE = 8'h06;
    localparam int         STAT_IRQ_BIT    = 7;
    localparam int         STAT_CNT_Z_BIT  = 4;

    // Bus phase sequence: counter holds at its last step
    localparam logic [3:0] PHASE_LAST = 4'd10;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] reg_index;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pulse;
    } t_result;

    // Phase code shown in the low status bits for each step
    function automatic logic [2:0] phase_code(input logic [3:0] step);
        logic [2:0] code;
        case (step)
            4'd0, 4'd1: code = 3'd0;
            4'd2, 4'd3: code = 3'd1;
            4'd4:       code = 3'd2;
            4'd5:       code = 3'd3;
            4'd6:       code = 3'd4;
            4'd7:       code = 3'd5;
            4'd8:       code = 3'd6;
            4'd9:       code = 3'd7;
            default:    code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* design/scsirb_in_reg.sv */
// Input register: holds one accepted beat until the execute step takes it.
`timescale 1ns / 1ps
`default_nettype none

module scsirb_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  scsirb_pkg::t_item   i_item,
    output logic                o_valid,
    output scsirb_pkg::t_item   o_item,
    input  wire                 i_take
);
    import scsirb_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Space whenever empty or the held beat leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* design/scsirb_exec.sv */
// Register file, command FIFO, phase counter and IRQ timer with their update logic.
`timescale 1ns / 1ps
`default_nettype none

module scsirb_exec (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  scsirb_pkg::t_item    i_item,
    output scsirb_pkg::t_result  o_result,
    input  wire                  i_cfg_we,
    input  wire [15:0]           i_cfg_data
);
    import scsirb_pkg::*;

    localparam logic [FIFO_PTR_W-1:0] PTR_MAX = FIFO_PTR_W'(FIFO_DEPTH - 1);

    logic [7:0]            r_mirror [16];
    logic [7:0]            n_mirror [16];
    logic [7:0]            r_fifo   [FIFO_DEPTH];
    logic [7:0]            n_fifo   [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_ptr,     n_ptr;
    logic [3:0]            r_phase,   n_phase;
    logic                  r_pending, n_pending;
    logic [15:0]           r_count,   n_count;
    logic [15:0]           r_delay;
    t_result               res;
    logic                  sched;

    assign o_result = res;

    // Next state and result for the beat in the execute step
    always_comb begin
        n_mirror  = r_mirror;
        n_fifo    = r_fifo;
        n_ptr     = r_ptr;
        n_phase   = r_phase;
        n_pending = r_pending;
        n_count   = r_count;
        res       = '0;
        sched     = 1'b0;
        if (i_fire) begin
            case (i_item.action)
                ACT_READ: begin
                    // status read inserts the phase code, then steps the phase
                    if (i_item.reg_index == ADDR_STATUS) begin
                        n_mirror[ADDR_STATUS][2:0] = phase_code(r_phase);
                        if (r_phase < PHASE_LAST) begin
                            n_phase = r_phase + 4'd1;
                        end
                    end
                    if (i_item.reg_index != ADDR_FIFO) begin
                        res.read_data = n_mirror[i_item.reg_index];
                    end
                    // reading interrupt status drops the IRQ bit
                    if (i_item.reg_index == ADDR_IRQ) begin
                        n_mirror[ADDR_STATUS][STAT_IRQ_BIT] = 1'b0;
                    end
                end
                ACT_WRITE: begin
                    if (i_item.reg_index == ADDR_CNT_LO || i_item.reg_index == ADDR_CNT_MID
                        || i_item.reg_index == ADDR_CNT_HI) begin
                        n_mirror[ADDR_STATUS][STAT_CNT_Z_BIT] = 1'b0;
                    end
                    // FIFO fill, last entry overwritten once full
                    if (i_item.reg_index == ADDR_FIFO) begin
                        n_fifo[r_ptr] = i_item.write_data;
                        n_ptr = (r_ptr == PTR_MAX) ? PTR_MAX : r_ptr + 1'b1;
                    end
                    if (i_item.reg_index == ADDR_CMD) begin
                        n_ptr = '0;
                        case (i_item.write_data[6:0])
                            CMD_NOP: begin
                                n_mirror[ADDR_IRQ] = ISTAT_DONE;
                                n_phase = '0;
                            end
                            CMD_RESET_DEV: begin
                                n_mirror[ADDR_ISTATE] = ISTATE_CMD_DONE;
                                n_phase = '0;
                                sched   = 1'b1;
                            end
                            CMD_SELECT_ATN: begin
                                sched = 1'b1;
                                if (r_fifo[1] == OPC_TEST_UNIT
                                    || r_fifo[1] == OPC_PLAY_TRK_IDX
                                    || r_fifo[1] == OPC_PAUSE_RESUME) begin
                                    n_mirror[ADDR_ISTATE] = ISTATE_SEQ_DONE;
                                end else begin
                                    n_mirror[ADDR_ISTATE] = ISTATE_CMD_DONE;
                                end
                                n_phase = '0;
                            end
                            CMD_ENABLE_SEL: begin
                                n_phase = '0;
                            end
                            CMD_XFER_INFO, CMD_INIT_CMPL, CMD_MSG_ACCEPT: begin
                                sched = 1'b1;
                                n_mirror[ADDR_ISTATE] = ISTATE_SEQ_DONE;
                            end
                            default: begin
                            end
                        endcase
                        // a new schedule restarts the single timer
                        if (sched) begin
                            n_pending = 1'b1;
                            n_count   = r_delay;
                        end
                    end
                    if (i_item.reg_index != ADDR_STATUS && i_item.reg_index != ADDR_IRQ
                        && i_item.reg_index != ADDR_ISTATE
                        && i_item.reg_index != ADDR_FSTATE) begin
                        n_mirror[i_item.reg_index] = i_item.write_data;
                    end
                end
                ACT_TICK: begin
                    if (r_pending) begin
                        if (r_count > 16'd1) begin
                            n_count = r_count - 16'd1;
                        end else begin
                            n_count   = '0;
                            n_pending = 1'b0;
                            n_mirror[ADDR_IRQ] = ISTAT_DONE;
                            n_mirror[ADDR_STATUS][STAT_IRQ_BIT] = 1'b1;
                            res.irq_pulse = 1'b1;
                        end
                    end
                end
                default: begin
                    n_mirror[ADDR_STATUS][STAT_CNT_Z_BIT] = 1'b1;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mirror[i] <= '0;
            end
            for (int i = 0; i < FIFO_DEPTH; i++) begin
                r_fifo[i] <= '0;
            end
            r_ptr     <= '0;
            r_phase   <= '0;
            r_pending <= 1'b0;
            r_count   <= '0;
        end else begin
            r_mirror  <= n_mirror;
            r_fifo    <= n_fifo;
            r_ptr     <= n_ptr;
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

    // IRQ delay setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= 16'd1;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_data;
        end
    end

endmodule

`default_nettype wire

/* design/scsirb_out_reg.sv */
// Result register: holds one result beat until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module scsirb_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  scsirb_pkg::t_result  i_result,
    output logic                 o_space,
    output logic                 o_valid,
    input  wire                  i_ready,
    output scsirb_pkg::t_result  o_result
);
    import scsirb_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room for a new result when empty or the held one goes this cycle
    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

/* design/scsi_controller_register_block.sv */
// Top level of the SCSI controller register block.
`timescale 1ns / 1ps
`default_nettype none

// Register-level model of a SCSI controller: reads, writes, timer ticks and
// DMA-done events arrive as beats on the slave stream (kind on tuser) and each
// gives exactly one result beat. A beat is registered in the input register and is
// executed, once the output register has room, against the register file, command
// FIFO, phase counter and IRQ timer, its result landing in the output register; one
// beat is taken every clock while the master side keeps up, one beat per cycle. The
// IRQ delay register is written on the config channel, which is always ready; the
// user must write it only while no beat is in flight: the block does not enforce it.
module scsi_controller_register_block (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [scsirb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // reg_index[3:0],
                                                               // write_data[11:4], zero pad
    input  wire  [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [scsirb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // read_data[7:0],
                                                               // irq_pulse[8], zero pad
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [15:0] i_cfg_data      // irq_delay_ticks
);
    import scsirb_pkg::*;

    t_item   in_item;
    t_item   held_item;
    t_result exec_result;
    t_result out_result;
    logic    held_valid;
    logic    out_space;
    logic    fire;

    assign in_item.action     = s_axis_tuser;
    assign in_item.reg_index  = s_axis_tdata[3:0];
    assign in_item.write_data = s_axis_tdata[11:4];

    // Execute whenever a beat is held and the result register has room
    assign fire        = held_valid && out_space;
    assign o_cfg_ready = 1'b1;

    scsirb_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (fire)
    );

    scsirb_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (held_item),
        .o_result   (exec_result),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data)
    );

    scsirb_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (exec_result),
        .o_space  (out_space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {7'd0, out_result.irq_pulse, out_result.read_data};

endmodule

`default_nettype wire
